### rtl/btc_pkg.sv
// shared types and constants for the block transposition cipher
`timescale 1ns / 1ps
`default_nettype none
package btc_pkg;

  localparam int MAX_BLOCK_DEF = 8;
  localparam int PERM_ENTRIES  = 8;
  localparam int ENT_W         = 3;
  localparam int JW            = 3;

  localparam logic [7:0]  SPACE_BYTE    = 8'h20;
  localparam logic [3:0]  BLOCK_LEN_RST = 4'd8;
  localparam logic [23:0] PERM_MAP_RST  = 24'hFAC688;

  // configuration register indexes
  localparam logic REG_BLOCK_LEN = 1'b0;
  localparam logic REG_PERM_MAP  = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_in_block;
    logic       message_done;
  } out_word_t;

  // one closed block: unfilled positions already hold a space
  typedef struct packed {
    logic [PERM_ENTRIES-1:0][7:0] bytes;
    logic [3:0]                   len;
    logic                         eom;
  } blk_t;

endpackage
`default_nettype wire

### rtl/btc_front.sv
// front end: collects bytes into the block buffer and closes blocks
`timescale 1ns / 1ps
`default_nettype none
module btc_front #(
  parameter int MAX_BLOCK = btc_pkg::MAX_BLOCK_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  input  wire btc_pkg::in_word_t in_word,
  input  wire logic [3:0]       block_len,
  output logic                  push,
  output btc_pkg::blk_t         push_blk
);
  import btc_pkg::*;

  localparam int CAP  = (MAX_BLOCK < PERM_ENTRIES) ? MAX_BLOCK : PERM_ENTRIES;
  localparam int IW   = $clog2(MAX_BLOCK);
  localparam int FW   = $clog2(MAX_BLOCK + 1);
  localparam int CMPW = (FW > 4) ? FW : 4;

  logic [7:0]    store_r [MAX_BLOCK];
  logic [FW-1:0] fill_r, fill_nxt, fill_new;
  logic [3:0]    len;
  logic          stored, close;

  // effective length: zero acts as one, large values clamp
  always_comb begin
    len = block_len;
    if (len == 4'd0) len = 4'd1;
    if (len > 4'(CAP)) len = 4'(CAP);
  end

  assign stored   = (fill_r < FW'(MAX_BLOCK));
  assign fill_new = stored ? fill_r + FW'(1) : fill_r;
  assign close    = in_word.end_of_message || (CMPW'(fill_new) >= CMPW'(len));
  assign push     = in_fire && close;

  always_comb begin
    fill_nxt = fill_r;
    if (in_fire) fill_nxt = close ? '0 : fill_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && stored) begin
      store_r[fill_r[IW-1:0]] <= in_word.data_byte;
    end
  end

  // snapshot of the closing block, incoming byte merged in
  always_comb begin
    push_blk.len = len;
    push_blk.eom = in_word.end_of_message;
    for (int i = 0; i < PERM_ENTRIES; i++) begin
      push_blk.bytes[i] = SPACE_BYTE;
      if (i < CAP) begin
        if (FW'(i) == fill_r) push_blk.bytes[i] = in_word.data_byte;
        else if (FW'(i) < fill_r) push_blk.bytes[i] = store_r[IW'(i)];
      end
    end
  end

endmodule
`default_nettype wire

### rtl/btc_queue.sv
// two-entry queue of closed blocks between front and back end
`timescale 1ns / 1ps
`default_nettype none
module btc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire btc_pkg::blk_t push_blk,
  input  wire logic          pop,
  output btc_pkg::blk_t      head,
  output logic               empty,
  output logic               full
);
  import btc_pkg::*;

  blk_t       mem_r [2];
  logic       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_blk;
  end

endmodule
`default_nettype wire

### rtl/btc_back.sv
// back end: walks the permutation and emits one word per cycle while out_stall is low
`timescale 1ns / 1ps
`default_nettype none
module btc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [23:0]   perm_map,
  input  wire btc_pkg::blk_t q_head,
  input  wire logic          q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output btc_pkg::out_word_t out_data
);
  import btc_pkg::*;

  blk_t            cur_r, cur_nxt;
  logic            busy_r, busy_nxt;
  logic [JW-1:0]   j_r, j_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_r, out_nxt, word;
  logic [ENT_W-1:0] src;
  logic            adv, last;

  assign src  = perm_map[5'(j_r) * 5'(ENT_W) +: ENT_W];
  assign last = (4'(j_r) == cur_r.len - 4'd1);
  assign adv  = !out_valid_r || !out_stall;

  always_comb begin
    word.out_byte      = (4'(src) < cur_r.len) ? cur_r.bytes[src] : SPACE_BYTE;
    word.last_in_block = last;
    word.message_done  = last && cur_r.eom;
  end

  always_comb begin
    cur_nxt       = cur_r;
    busy_nxt      = busy_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    if (busy_r) begin
      if (adv) begin
        out_nxt       = word;
        out_valid_nxt = 1'b1;
        if (last) begin
          // chain straight into the next block when one is waiting
          if (!q_empty) begin
            q_pop   = 1'b1;
            cur_nxt = q_head;
            j_nxt   = '0;
          end else begin
            busy_nxt = 1'b0;
          end
        end else begin
          j_nxt = j_r + JW'(1);
        end
      end
    end else begin
      if (adv) out_valid_nxt = 1'b0;
      if (!q_empty) begin
        q_pop    = 1'b1;
        cur_nxt  = q_head;
        busy_nxt = 1'b1;
        j_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      j_r         <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      j_r         <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### rtl/block_transposition_cipher_top.sv
// top level of the block transposition cipher
// usage:
//   in_valid/in_stall/in_data carry one message byte per word, with an
//   end-of-message flag. a word is taken when in_valid is high and in_stall low.
//   out_valid/out_stall/out_data return permuted bytes; a word leaves when
//   out_valid is high and out_stall low. each closed block gives a run of its
//   clamped length in words, the last flagged, message_done if closed by eom.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write block_len (index 0) and
//   perm_map (index 1); cfg_ready is always high, write only while idle.
// timing:
//   the front end takes one byte per cycle while in_stall is low; the back end
//   emits one word per cycle while out_stall is low, so the sustained rate is
//   one byte per cycle. the first word of a run reaches the output through
//   the block load and then the output register, once the back end is free;
//   the queue is written at the edge that takes the closing byte.
// reset: fill count, queue and output valid clear; config returns to length 8
//   and the identity map. when out_stall holds, the output register keeps its
//   word, the two-entry block queue fills and then in_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module block_transposition_cipher_top #(
  parameter int MAX_BLOCK = btc_pkg::MAX_BLOCK_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // byte input
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire btc_pkg::in_word_t  in_data,
  // permuted output
  output logic                    out_valid,
  input  wire logic               out_stall,
  output btc_pkg::out_word_t      out_data,
  // register writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [23:0]        cfg_data
);
  import btc_pkg::*;

  logic [3:0]  block_len_r, block_len_nxt;
  logic [23:0] perm_map_r, perm_map_nxt;
  logic        in_fire;
  logic        push, pop, q_empty, q_full;
  blk_t        push_blk, q_head;

  // config registers, always writable
  assign cfg_ready = 1'b1;

  always_comb begin
    block_len_nxt = block_len_r;
    perm_map_nxt  = perm_map_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLOCK_LEN: block_len_nxt = cfg_data[3:0];
        REG_PERM_MAP:  perm_map_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_len_r <= BLOCK_LEN_RST;
      perm_map_r  <= PERM_MAP_RST;
    end else begin
      block_len_r <= block_len_nxt;
      perm_map_r  <= perm_map_nxt;
    end
  end

  // hold input off while no queue slot is free for a closing block
  assign in_stall = q_full;
  assign in_fire  = in_valid && !in_stall;

  btc_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_word   (in_data),
    .block_len (block_len_r),
    .push      (push),
    .push_blk  (push_blk)
  );

  btc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_blk (push_blk),
    .pop      (pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  btc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .perm_map  (perm_map_r),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
